// ===== src/lbc_pkg.sv =====
// ============================================================================
// lbc_pkg
// Types and codes shared by the block buffer cache controller.
// ============================================================================
`timescale 1ns / 1ps

package lbc_pkg;

    localparam int CMD_W  = 3;
    localparam int BLK_W  = 24;
    localparam int SLOT_W = 4;
    localparam int OP_W   = 2;

    // command codes
    localparam logic [CMD_W-1:0] CMD_GET           = 3'd0;
    localparam logic [CMD_W-1:0] CMD_READ          = 3'd1;
    localparam logic [CMD_W-1:0] CMD_RELEASE       = 3'd2;
    localparam logic [CMD_W-1:0] CMD_WRITE_NOW     = 3'd3;
    localparam logic [CMD_W-1:0] CMD_WRITE_DELAYED = 3'd4;
    localparam logic [CMD_W-1:0] CMD_FLUSH         = 3'd5;

    // disk request codes
    localparam logic [OP_W-1:0] DOP_NONE  = 2'd0;
    localparam logic [OP_W-1:0] DOP_READ  = 2'd1;
    localparam logic [OP_W-1:0] DOP_WRITE = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [BLK_W-1:0]  block_number;
        logic [SLOT_W-1:0] buffer_index;
    } cmd_t;

    typedef struct packed {
        logic [OP_W-1:0]   disk_op;
        logic [BLK_W-1:0]  disk_block;
        logic [SLOT_W-1:0] buf_slot;
        logic              hit;
        logic              status;
        logic              last;
    } rsp_t;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_SCAN,
        ST_FETCH,
        ST_UPDATE,
        ST_WB,
        ST_EMIT,
        ST_REL,
        ST_REL_RES,
        ST_FL_RD,
        ST_FL_WB
    } state_t;

endpackage

// ===== src/lru_block_buffer_cache.sv =====
// ============================================================================
// lru_block_buffer_cache
// Tag and LRU replacement controller of a disk block buffer cache.
//
// Command beats enter on cmd_valid/cmd_stall, one at a time; result beats
// leave on rsp_valid/rsp_stall through an output register, so a new command
// is taken while the previous final result still waits. A command yields one
// or more result beats; the final one carries last.
// Get/read scan the tag memory one entry a cycle and stop at a hit; the tag
// memory read port sets the scan rate.
// Reset: marks clear, every buffer goes on the free list, and a link-memory
// init pass runs before the first command is taken.
// A stalled result beat holds; the controller waits for it before pushing
// the next beat of the same command.
// ============================================================================
`timescale 1ns / 1ps

module lru_block_buffer_cache #(
    parameter int NUM_BUFFERS = 16,
    parameter int BLOCK_BITS  = 24
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_stall,
    input  lbc_pkg::cmd_t cmd_data,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output lbc_pkg::rsp_t rsp_data
);

    import lbc_pkg::*;

    localparam int IDX_W = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;
    localparam int CNT_W = IDX_W + 1;
    localparam int TAG_W = (BLOCK_BITS < BLK_W) ? BLOCK_BITS : BLK_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_BUFFERS - 1);
    localparam logic [CNT_W-1:0] NB_CNT   = CNT_W'(NUM_BUFFERS);

    // storage
    logic [TAG_W-1:0] tag_mem  [NUM_BUFFERS];
    logic [IDX_W-1:0] next_mem [NUM_BUFFERS];
    logic [IDX_W-1:0] prev_mem [NUM_BUFFERS];
    logic [TAG_W-1:0] tag_rd_reg;
    logic [IDX_W-1:0] next_rd_reg;
    logic [IDX_W-1:0] prev_rd_reg;

    logic             tag_re, tag_we, link_re, next_we, prev_we;
    logic [IDX_W-1:0] tag_ra, tag_wa, link_ra, next_wa, prev_wa;
    logic [TAG_W-1:0] tag_wd;
    logic [IDX_W-1:0] next_wd, prev_wd;

    // control and marks
    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             rd_pend_reg, rd_pend_next;
    logic [IDX_W-1:0] rd_idx_reg, rd_idx_next;
    logic [CMD_W-1:0] cmd_reg, cmd_next;
    logic [TAG_W-1:0] blk_reg, blk_next;
    logic [IDX_W-1:0] slot_reg, slot_next;
    logic             hit_reg, hit_next;
    rsp_t             pend_reg, pend_next;
    logic [NUM_BUFFERS-1:0] valid_reg, valid_next;
    logic [NUM_BUFFERS-1:0] dirty_reg, dirty_next;
    logic [NUM_BUFFERS-1:0] done_reg, done_next;
    logic [NUM_BUFFERS-1:0] free_reg, free_next;
    logic [IDX_W-1:0] oldest_reg, oldest_next;
    logic [IDX_W-1:0] newest_reg, newest_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             rsp_valid_reg, rsp_valid_next;
    rsp_t             rsp_data_reg, rsp_data_next;

    logic             cmd_fire, rsp_free, scan_hit, scan_miss, cnt_at_end;
    logic             idx_in_range, victim_dirty, fetch;
    logic [IDX_W-1:0] cnt_idx;

    assign cmd_stall    = (state_reg != ST_IDLE);
    assign cmd_fire     = cmd_valid && !cmd_stall;
    assign rsp_valid    = rsp_valid_reg;
    assign rsp_data     = rsp_data_reg;
    assign rsp_free     = !rsp_valid_reg || !rsp_stall;
    assign cnt_idx      = cnt_reg[IDX_W-1:0];
    assign cnt_at_end   = (cnt_reg == NB_CNT);
    assign idx_in_range = int'(cmd_data.buffer_index) < NUM_BUFFERS;
    // tag compare uses the registered read, in the cycle after the read address
    assign scan_hit     = rd_pend_reg && valid_reg[rd_idx_reg] && (tag_rd_reg == blk_reg);
    assign scan_miss    = rd_pend_reg && !scan_hit && (rd_idx_reg == LAST_IDX);
    assign victim_dirty = !hit_reg && dirty_reg[slot_reg];
    assign fetch        = (cmd_reg == CMD_READ) &&
                          (hit_reg ? (!done_reg[slot_reg] && !dirty_reg[slot_reg]) : 1'b1);

    // memories
    always_ff @(posedge clk)
    begin
        if (tag_we)
        begin
            tag_mem[tag_wa] <= tag_wd;
        end
        if (tag_re)
        begin
            tag_rd_reg <= tag_mem[tag_ra];
        end
    end

    always_ff @(posedge clk)
    begin
        if (next_we)
        begin
            next_mem[next_wa] <= next_wd;
        end
        if (prev_we)
        begin
            prev_mem[prev_wa] <= prev_wd;
        end
        if (link_re)
        begin
            next_rd_reg <= next_mem[link_ra];
            prev_rd_reg <= prev_mem[link_ra];
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_INIT:
            begin
                if (cnt_idx == LAST_IDX)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (cmd_fire)
                begin
                    case (cmd_data.command)
                        CMD_GET, CMD_READ:
                        begin
                            state_next = ST_SCAN;
                        end
                        CMD_RELEASE, CMD_WRITE_NOW, CMD_WRITE_DELAYED:
                        begin
                            state_next = idx_in_range ? ST_REL : ST_EMIT;
                        end
                        CMD_FLUSH:
                        begin
                            state_next = ST_FL_RD;
                        end
                        default:
                        begin
                            state_next = ST_EMIT;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (scan_hit)
                begin
                    state_next = ST_FETCH;
                end
                else if (scan_miss)
                begin
                    state_next = (count_reg == '0) ? ST_EMIT : ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                state_next = victim_dirty ? ST_WB : ST_EMIT;
            end
            ST_WB:
            begin
                if (rsp_free)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (rsp_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_REL:
            begin
                state_next = ST_REL_RES;
            end
            ST_REL_RES:
            begin
                state_next = ST_EMIT;
            end
            ST_FL_RD:
            begin
                if (cnt_at_end)
                begin
                    state_next = ST_EMIT;
                end
                else if (dirty_reg[cnt_idx])
                begin
                    state_next = ST_FL_WB;
                end
            end
            ST_FL_WB:
            begin
                if (rsp_free)
                begin
                    state_next = ST_FL_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and memory controls
    always_comb
    begin
        cnt_next       = cnt_reg;
        rd_pend_next   = 1'b0;
        rd_idx_next    = rd_idx_reg;
        cmd_next       = cmd_reg;
        blk_next       = blk_reg;
        slot_next      = slot_reg;
        hit_next       = hit_reg;
        pend_next      = pend_reg;
        valid_next     = valid_reg;
        dirty_next     = dirty_reg;
        done_next      = done_reg;
        free_next      = free_reg;
        oldest_next    = oldest_reg;
        newest_next    = newest_reg;
        count_next     = count_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_data_next  = rsp_data_reg;
        tag_re  = 1'b0;
        tag_ra  = slot_reg;
        tag_we  = 1'b0;
        tag_wa  = slot_reg;
        tag_wd  = blk_reg;
        link_re = 1'b0;
        link_ra = slot_reg;
        next_we = 1'b0;
        next_wa = slot_reg;
        next_wd = slot_reg;
        prev_we = 1'b0;
        prev_wa = slot_reg;
        prev_wd = slot_reg;

        case (state_reg)
            ST_INIT:
            begin
                // ring links: i -> i+1, i -> i-1
                next_we  = 1'b1;
                next_wa  = cnt_idx;
                next_wd  = (cnt_idx == LAST_IDX) ? '0 : cnt_idx + IDX_W'(1);
                prev_we  = 1'b1;
                prev_wa  = cnt_idx;
                prev_wd  = (cnt_idx == '0) ? LAST_IDX : cnt_idx - IDX_W'(1);
                cnt_next = cnt_reg + CNT_W'(1);
            end
            ST_IDLE:
            begin
                if (cmd_fire)
                begin
                    cmd_next  = cmd_data.command;
                    blk_next  = TAG_W'(cmd_data.block_number);
                    slot_next = IDX_W'(cmd_data.buffer_index);
                    cnt_next  = '0;
                    pend_next = '0;
                    pend_next.last = 1'b1;
                    case (cmd_data.command)
                        CMD_RELEASE, CMD_WRITE_NOW, CMD_WRITE_DELAYED:
                        begin
                            pend_next.buf_slot = cmd_data.buffer_index;
                        end
                        default:
                        begin
                            pend_next.buf_slot = '0;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                tag_re       = !cnt_at_end;
                tag_ra       = cnt_idx;
                rd_pend_next = !cnt_at_end;
                rd_idx_next  = cnt_idx;
                if (!cnt_at_end)
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
                if (scan_hit)
                begin
                    slot_next = rd_idx_reg;
                    hit_next  = 1'b1;
                end
                else if (scan_miss)
                begin
                    slot_next        = oldest_reg;
                    hit_next         = 1'b0;
                    pend_next        = '0;
                    pend_next.status = 1'b1;
                    pend_next.last   = 1'b1;
                end
            end
            ST_FETCH:
            begin
                tag_re  = 1'b1;
                link_re = 1'b1;
            end
            ST_UPDATE:
            begin
                if (free_reg[slot_reg])
                begin
                    if (slot_reg == oldest_reg)
                    begin
                        oldest_next = next_rd_reg;
                    end
                    else
                    begin
                        next_we = 1'b1;
                        next_wa = prev_rd_reg;
                        next_wd = next_rd_reg;
                    end
                    if (slot_reg == newest_reg)
                    begin
                        newest_next = prev_rd_reg;
                    end
                    else
                    begin
                        prev_we = 1'b1;
                        prev_wa = next_rd_reg;
                        prev_wd = prev_rd_reg;
                    end
                    free_next[slot_reg] = 1'b0;
                    count_next = count_reg - CNT_W'(1);
                end
                if (!hit_reg)
                begin
                    tag_we               = 1'b1;
                    valid_next[slot_reg] = 1'b1;
                    dirty_next[slot_reg] = 1'b0;
                    done_next[slot_reg]  = fetch;
                end
                else
                begin
                    done_next[slot_reg] = done_reg[slot_reg] | fetch;
                end
                pend_next.disk_op    = fetch ? DOP_READ : DOP_NONE;
                pend_next.disk_block = fetch ? BLK_W'(blk_reg) : '0;
                pend_next.buf_slot   = SLOT_W'(slot_reg);
                pend_next.hit        = hit_reg;
                pend_next.status     = 1'b0;
                pend_next.last       = 1'b1;
            end
            ST_WB:
            begin
                // victim tag still sits in the read register
                if (rsp_free)
                begin
                    rsp_valid_next           = 1'b1;
                    rsp_data_next            = '0;
                    rsp_data_next.disk_op    = DOP_WRITE;
                    rsp_data_next.disk_block = BLK_W'(tag_rd_reg);
                    rsp_data_next.buf_slot   = SLOT_W'(slot_reg);
                end
            end
            ST_EMIT:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_data_next  = pend_reg;
                end
            end
            ST_REL:
            begin
                tag_re = 1'b1;
                if (cmd_reg == CMD_WRITE_NOW)
                begin
                    dirty_next[slot_reg] = 1'b0;
                    done_next[slot_reg]  = 1'b1;
                end
                else if (cmd_reg == CMD_WRITE_DELAYED)
                begin
                    dirty_next[slot_reg] = 1'b1;
                    done_next[slot_reg]  = 1'b1;
                end
                // append as newest free unless already on the list
                if (!free_reg[slot_reg])
                begin
                    if (count_reg == '0)
                    begin
                        oldest_next = slot_reg;
                    end
                    else
                    begin
                        next_we = 1'b1;
                        next_wa = newest_reg;
                        next_wd = slot_reg;
                        prev_we = 1'b1;
                        prev_wa = slot_reg;
                        prev_wd = newest_reg;
                    end
                    newest_next         = slot_reg;
                    free_next[slot_reg] = 1'b1;
                    count_next          = count_reg + CNT_W'(1);
                end
            end
            ST_REL_RES:
            begin
                pend_next          = '0;
                pend_next.buf_slot = SLOT_W'(slot_reg);
                pend_next.last     = 1'b1;
                if (cmd_reg == CMD_WRITE_NOW)
                begin
                    pend_next.disk_op    = DOP_WRITE;
                    pend_next.disk_block = BLK_W'(tag_rd_reg);
                end
            end
            ST_FL_RD:
            begin
                if (cnt_at_end)
                begin
                    pend_next      = '0;
                    pend_next.last = 1'b1;
                end
                else if (dirty_reg[cnt_idx])
                begin
                    tag_re = 1'b1;
                    tag_ra = cnt_idx;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ST_FL_WB:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next           = 1'b1;
                    rsp_data_next            = '0;
                    rsp_data_next.disk_op    = DOP_WRITE;
                    rsp_data_next.disk_block = BLK_W'(tag_rd_reg);
                    rsp_data_next.buf_slot   = SLOT_W'(cnt_idx);
                    dirty_next[cnt_idx]      = 1'b0;
                    done_next[cnt_idx]       = 1'b1;
                    cnt_next                 = cnt_reg + CNT_W'(1);
                end
            end
            default:
            begin
                cnt_next = cnt_reg;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            cnt_reg       <= '0;
            rd_pend_reg   <= 1'b0;
            valid_reg     <= '0;
            dirty_reg     <= '0;
            done_reg      <= '0;
            free_reg      <= '1;
            oldest_reg    <= '0;
            newest_reg    <= LAST_IDX;
            count_reg     <= NB_CNT;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            rd_pend_reg   <= rd_pend_next;
            valid_reg     <= valid_next;
            dirty_reg     <= dirty_next;
            done_reg      <= done_next;
            free_reg      <= free_next;
            oldest_reg    <= oldest_next;
            newest_reg    <= newest_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        rd_idx_reg   <= rd_idx_next;
        cmd_reg      <= cmd_next;
        blk_reg      <= blk_next;
        slot_reg     <= slot_next;
        hit_reg      <= hit_next;
        pend_reg     <= pend_next;
        rsp_data_reg <= rsp_data_next;
    end

endmodule

// ===== sim/tb_lru_block_buffer_cache.sv =====
// ============================================================================
// tb_lru_block_buffer_cache
// Self-checking testbench for the block buffer cache tag/LRU controller.
//
// A short table of directed commands runs first: fill and overflow of the
// cache, dirty eviction, release of a free buffer, write-now, flush, and
// unused command codes. Random command streams follow in four phases with
// different sender idle and receiver stall rates. Every result beat is
// compared field by field: typed table rows against the beat in the table,
// all others against an in-bench model of the tag store and the free list.
// ============================================================================
`timescale 1ns / 1ps

module tb_lru_block_buffer_cache;

    import lbc_pkg::*;

    localparam int NBUF           = 16;
    localparam int POOL_N         = 20;
    localparam int RAND_ITEMS     = 332;
    localparam int PHASES         = 4;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 40;

    // command codes the block does not define
    localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

    typedef struct {
        cmd_t item;
        bit   typed;
        rsp_t want;
    } dir_row_t;

    logic clk;
    logic rst_n     = 1'b0;
    logic cmd_valid = 1'b0;
    logic cmd_stall;
    cmd_t cmd_data  = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp_data;

    // cache image kept by the bench
    logic [BLK_W-1:0]  tag_mem [NBUF];
    bit                vld     [NBUF];
    bit                drt     [NBUF];
    bit                dn      [NBUF];
    bit                fr      [NBUF];
    logic [SLOT_W-1:0] nxt     [NBUF];
    logic [SLOT_W-1:0] prv     [NBUF];
    logic [SLOT_W-1:0] oldest;
    logic [SLOT_W-1:0] newest;
    int                nfree;

    rsp_t              cmd_rsp[$];
    rsp_t              due_rsp[$];
    dir_row_t          dir_rows[$];
    logic [BLK_W-1:0]  blk_pool[POOL_N];

    int gap_pct   = 0;
    int stall_pct = 0;
    int n_err     = 0;
    int n_items   = 0;
    int n_beats   = 0;
    int n_hits    = 0;
    int n_wb      = 0;
    int n_full    = 0;
    int n_flush   = 0;
    int idle_cycles = 0;

    lru_block_buffer_cache #(
        .NUM_BUFFERS(NBUF),
        .BLOCK_BITS (BLK_W)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd_valid(cmd_valid),
        .cmd_stall(cmd_stall),
        .cmd_data (cmd_data),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp_data (rsp_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic rsp_t mk_rsp(input logic [OP_W-1:0] op, input logic [BLK_W-1:0] blk,
                                    input logic [SLOT_W-1:0] slot, input logic hit,
                                    input logic st, input logic fin);
        rsp_t r;
        r.disk_op    = op;
        r.disk_block = blk;
        r.buf_slot   = slot;
        r.hit        = hit;
        r.status     = st;
        r.last       = fin;
        return r;
    endfunction

    task automatic cache_clear();
        int i;
        for (i = 0; i < NBUF; i++)
        begin
            tag_mem[i] = '0;
            vld[i]     = 1'b0;
            drt[i]     = 1'b0;
            dn[i]      = 1'b0;
            fr[i]      = 1'b1;
            nxt[i]     = SLOT_W'((i + 1) % NBUF);
            prv[i]     = SLOT_W'((i + NBUF - 1) % NBUF);
        end
        oldest = '0;
        newest = SLOT_W'(NBUF - 1);
        nfree  = NBUF;
    endtask

    task automatic take_free(input logic [SLOT_W-1:0] i);
        if (fr[i])
        begin
            if (i == oldest)
                oldest = nxt[i];
            else
                nxt[prv[i]] = nxt[i];
            if (i == newest)
                newest = prv[i];
            else
                prv[nxt[i]] = prv[i];
            fr[i] = 1'b0;
            nfree--;
        end
    endtask

    task automatic give_free(input logic [SLOT_W-1:0] i);
        if (!fr[i])
        begin
            if (nfree == 0)
                oldest = i;
            else
            begin
                nxt[newest] = i;
                prv[i]      = newest;
            end
            newest = i;
            fr[i]  = 1'b1;
            nfree++;
        end
    endtask

    // Updates the cache image for one command; its result beats land in cmd_rsp.
    task automatic apply_cmd(input cmd_t c);
        logic [SLOT_W-1:0] slot;
        bit                found;
        int                i;
        cmd_rsp.delete();
        case (c.command)
            CMD_GET, CMD_READ:
            begin
                found = 1'b0;
                slot  = '0;
                for (i = 0; i < NBUF; i++)
                begin
                    if (!found && vld[i] && tag_mem[i] == c.block_number)
                    begin
                        found = 1'b1;
                        slot  = SLOT_W'(i);
                    end
                end
                if (!found && nfree == 0)
                begin
                    cmd_rsp.push_back(mk_rsp(DOP_NONE, '0, '0, 1'b0, 1'b1, 1'b1));
                    n_full++;
                end
                else
                begin
                    if (found)
                    begin
                        take_free(slot);
                        n_hits++;
                    end
                    else
                    begin
                        slot = oldest;
                        take_free(slot);
                        if (drt[slot])
                        begin
                            cmd_rsp.push_back(mk_rsp(DOP_WRITE, tag_mem[slot], slot,
                                                     1'b0, 1'b0, 1'b0));
                            n_wb++;
                        end
                        drt[slot]     = 1'b0;
                        dn[slot]      = 1'b0;
                        tag_mem[slot] = c.block_number;
                        vld[slot]     = 1'b1;
                    end
                    // dirty or done buffers already hold the data
                    if (c.command == CMD_READ && !dn[slot] && !drt[slot])
                    begin
                        dn[slot] = 1'b1;
                        cmd_rsp.push_back(mk_rsp(DOP_READ, c.block_number, slot, found,
                                                 1'b0, 1'b1));
                    end
                    else
                        cmd_rsp.push_back(mk_rsp(DOP_NONE, '0, slot, found, 1'b0, 1'b1));
                end
            end
            CMD_RELEASE, CMD_WRITE_NOW, CMD_WRITE_DELAYED:
            begin
                slot = c.buffer_index;
                if (c.command == CMD_WRITE_NOW)
                begin
                    drt[slot] = 1'b0;
                    dn[slot]  = 1'b1;
                    cmd_rsp.push_back(mk_rsp(DOP_WRITE, tag_mem[slot], slot, 1'b0, 1'b0, 1'b1));
                    n_wb++;
                end
                else
                begin
                    if (c.command == CMD_WRITE_DELAYED)
                    begin
                        drt[slot] = 1'b1;
                        dn[slot]  = 1'b1;
                    end
                    cmd_rsp.push_back(mk_rsp(DOP_NONE, '0, slot, 1'b0, 1'b0, 1'b1));
                end
                give_free(slot);
            end
            CMD_FLUSH:
            begin
                for (i = 0; i < NBUF; i++)
                begin
                    if (drt[i])
                    begin
                        drt[i] = 1'b0;
                        dn[i]  = 1'b1;
                        cmd_rsp.push_back(mk_rsp(DOP_WRITE, tag_mem[i], SLOT_W'(i),
                                                 1'b0, 1'b0, 1'b0));
                        n_wb++;
                    end
                end
                cmd_rsp.push_back(mk_rsp(DOP_NONE, '0, '0, 1'b0, 1'b0, 1'b1));
                n_flush++;
            end
            default:
                cmd_rsp.push_back(mk_rsp(DOP_NONE, '0, '0, 1'b0, 1'b0, 1'b1));
        endcase
    endtask

    task automatic add_row(input logic [CMD_W-1:0] cmd, input logic [BLK_W-1:0] blk,
                           input logic [SLOT_W-1:0] idx, input bit typed, input rsp_t want);
        dir_row_t row;
        row.item.command      = cmd;
        row.item.block_number = blk;
        row.item.buffer_index = idx;
        row.typed             = typed;
        row.want              = want;
        dir_rows.push_back(row);
    endtask

    task automatic send_cmd(input cmd_t c, input bit typed, input rsp_t want);
        int k;
        while ($urandom_range(0, 99) < gap_pct)
        begin
            @(negedge clk);
            cmd_valid <= 1'b0;
        end
        @(negedge clk);
        cmd_valid <= 1'b1;
        cmd_data  <= c;
        do
            @(posedge clk);
        while (!(cmd_valid && !cmd_stall));
        apply_cmd(c);
        n_items++;
        if (typed)
            due_rsp.push_back(want);
        else
            for (k = 0; k < cmd_rsp.size(); k++)
                due_rsp.push_back(cmd_rsp[k]);
    endtask

    task automatic hold_until_drained();
        @(negedge clk);
        cmd_valid <= 1'b0;
        while (due_rsp.size() != 0)
            @(posedge clk);
    endtask

    function automatic cmd_t random_cmd();
        cmd_t c;
        int   r;
        int   i;
        int   busy[$];
        c.command      = CMD_GET;
        c.block_number = BLK_W'($urandom);
        c.buffer_index = SLOT_W'($urandom_range(0, NBUF - 1));
        r = $urandom_range(0, 99);
        if (r < 42)
        begin
            c.command = ($urandom_range(0, 1) != 0) ? CMD_READ : CMD_GET;
            // mostly a small working set so that hits and reuse happen
            if ($urandom_range(0, 3) != 0)
                c.block_number = blk_pool[$urandom_range(0, POOL_N - 1)];
        end
        else if (r < 90)
        begin
            case ($urandom_range(0, 2))
                0:       c.command = CMD_RELEASE;
                1:       c.command = CMD_WRITE_NOW;
                default: c.command = CMD_WRITE_DELAYED;
            endcase
            for (i = 0; i < NBUF; i++)
                if (!fr[i])
                    busy.push_back(i);
            if (busy.size() != 0 && $urandom_range(0, 9) != 0)
                c.buffer_index = SLOT_W'(busy[$urandom_range(0, busy.size() - 1)]);
            // a write on a buffer that never held a block would write back garbage
            if (c.command != CMD_RELEASE && !vld[c.buffer_index])
                c.command = CMD_RELEASE;
        end
        else if (r < 96)
            c.command = CMD_FLUSH;
        else
            c.command = ($urandom_range(0, 1) != 0) ? CMD_SPARE_7 : CMD_SPARE_6;
        return c;
    endfunction

    task automatic check_rsp(input rsp_t want, input rsp_t got);
        if (got.disk_op !== want.disk_op)
        begin
            $error("disk_op: expected %0d, got %0d", want.disk_op, got.disk_op);
            n_err++;
        end
        if (got.disk_block !== want.disk_block)
        begin
            $error("disk_block: expected %06h, got %06h", want.disk_block, got.disk_block);
            n_err++;
        end
        if (got.buf_slot !== want.buf_slot)
        begin
            $error("buf_slot: expected %0d, got %0d", want.buf_slot, got.buf_slot);
            n_err++;
        end
        if (got.hit !== want.hit)
        begin
            $error("hit: expected %0d, got %0d", want.hit, got.hit);
            n_err++;
        end
        if (got.status !== want.status)
        begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            n_err++;
        end
        if (got.last !== want.last)
        begin
            $error("last: expected %0d, got %0d", want.last, got.last);
            n_err++;
        end
    endtask

    always @(negedge clk)
    begin
        rsp_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid === 1'b1 && !rsp_stall)
        begin
            n_beats++;
            if (due_rsp.size() == 0)
            begin
                $error("result beat with nothing expected: op %0d block %06h slot %0d",
                       rsp_data.disk_op, rsp_data.disk_block, rsp_data.buf_slot);
                n_err++;
            end
            else
                check_rsp(due_rsp.pop_front(), rsp_data);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((cmd_valid && !cmd_stall) || (rsp_valid === 1'b1 && !rsp_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: %0d cycles without a beat, %0d results outstanding",
                         idle_cycles, due_rsp.size());
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial
    begin
        rsp_t none;
        cmd_t c;
        int   k;
        int   ph;
        int   gap_tab[PHASES];
        int   stall_tab[PHASES];

        gap_tab   = '{0, 66, 0, 22};
        stall_tab = '{0, 0, 66, 22};
        none      = '0;
        cache_clear();

        // fill all sixteen buffers, overflow, then exercise release paths
        add_row(CMD_READ, 24'hFFFFFF, 4'd0, 1'b1,
                mk_rsp(DOP_READ, 24'hFFFFFF, 4'd0, 1'b0, 1'b0, 1'b1));
        add_row(CMD_GET, 24'h000000, 4'd0, 1'b1,
                mk_rsp(DOP_NONE, '0, 4'd1, 1'b0, 1'b0, 1'b1));
        add_row(CMD_READ, 24'h000000, 4'd0, 1'b0, none);
        for (k = 2; k < NBUF; k++)
            add_row(CMD_GET, 24'h0F0F00 + BLK_W'(k), 4'd0, 1'b0, none);
        add_row(CMD_GET, 24'h123456, 4'd0, 1'b1,
                mk_rsp(DOP_NONE, '0, '0, 1'b0, 1'b1, 1'b1));
        add_row(CMD_WRITE_DELAYED, 24'h0, 4'd2, 1'b1,
                mk_rsp(DOP_NONE, '0, 4'd2, 1'b0, 1'b0, 1'b1));
        add_row(CMD_RELEASE, 24'h0, 4'd2, 1'b1,
                mk_rsp(DOP_NONE, '0, 4'd2, 1'b0, 1'b0, 1'b1));
        add_row(CMD_WRITE_NOW, 24'h0, 4'd15, 1'b0, none);
        add_row(CMD_GET, 24'h654321, 4'd0, 1'b0, none);
        add_row(CMD_WRITE_DELAYED, 24'h0, 4'd5, 1'b1,
                mk_rsp(DOP_NONE, '0, 4'd5, 1'b0, 1'b0, 1'b1));
        add_row(CMD_READ, 24'h0F0F0F, 4'd0, 1'b0, none);
        add_row(CMD_FLUSH, 24'h0, 4'd0, 1'b0, none);
        add_row(CMD_FLUSH, 24'h0, 4'd0, 1'b1,
                mk_rsp(DOP_NONE, '0, '0, 1'b0, 1'b0, 1'b1));
        add_row(CMD_SPARE_6, 24'hFFFFFF, 4'd15, 1'b1,
                mk_rsp(DOP_NONE, '0, '0, 1'b0, 1'b0, 1'b1));
        add_row(CMD_SPARE_7, 24'h0, 4'd0, 1'b1,
                mk_rsp(DOP_NONE, '0, '0, 1'b0, 1'b0, 1'b1));

        for (k = 0; k < POOL_N; k++)
            blk_pool[k] = BLK_W'($urandom);

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (k = 0; k < dir_rows.size(); k++)
            send_cmd(dir_rows[k].item, dir_rows[k].typed, dir_rows[k].want);
        hold_until_drained();

        for (ph = 0; ph < PHASES; ph++)
        begin
            gap_pct   = gap_tab[ph];
            stall_pct = stall_tab[ph];
            for (k = 0; k < RAND_ITEMS / PHASES; k++)
            begin
                c = random_cmd();
                send_cmd(c, 1'b0, none);
            end
            // let the cache settle before the next traffic profile
            hold_until_drained();
        end

        stall_pct = 0;
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Ran %0d commands (%0d from the table), %0d result beats checked.",
                 n_items, dir_rows.size(), n_beats);
        $display("Saw %0d hits, %0d write-backs, %0d no-free refusals, %0d flushes.",
                 n_hits, n_wb, n_full, n_flush);
        if (n_err == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== lru_block_buffer_cache.f =====
src/lbc_pkg.sv
src/lru_block_buffer_cache.sv
sim/tb_lru_block_buffer_cache.sv
